[sv/mqpf_pkg.sv]
package mqpf_pkg;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_TOPIC   = 2'd1;
   localparam logic [1:0] OP_PAYLOAD = 2'd2;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_TOPIC   = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam logic [7:0] HEADER_BASE = 8'h30;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Byte slots of one command, emitted in ascending order when their mask bit is set.
   localparam logic [2:0] SLOT_FIRST   = 3'd0;
   localparam logic [2:0] SLOT_LEN0    = 3'd1;
   localparam logic [2:0] SLOT_LEN1    = 3'd2;
   localparam logic [2:0] SLOT_LEN2    = 3'd3;
   localparam logic [2:0] SLOT_TLEN_HI = 3'd4;
   localparam logic [2:0] SLOT_TLEN_LO = 3'd5;
   localparam logic [2:0] SLOT_PID_HI  = 3'd6;
   localparam logic [2:0] SLOT_PID_LO  = 3'd7;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [1:0]  qos_level;
      logic        dup_flag;
      logic        retain_flag;
      logic [15:0] topic_length;
      logic [15:0] payload_length;
      logic [15:0] packet_id;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       error_flag;
   } rsp_item_type;

   typedef struct packed {
      logic        err;
      logic        end_after;
      logic [7:0]  mask;
      logic [7:0]  first_byte;
      logic [15:0] rem_len;
      logic [15:0] topic_len;
      logic [15:0] pid;
   } cmd_type;

endpackage

[sv/mqpf_front.sv]
module mqpf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  mqpf_pkg::req_item_type req_item,
   output mqpf_pkg::cmd_type     cmd
);

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] topic_left_ff, topic_left_in;
   logic [15:0] payload_left_ff, payload_left_in;
   logic        held_qnz_ff, held_qnz_in;
   logic [15:0] held_pid_ff, held_pid_in;

   logic [1:0]  qos_eff;
   logic        qnz;
   logic [17:0] rem_sum;
   logic        too_long;
   logic [15:0] topic_dec;
   logic [15:0] payload_dec;

   always_comb begin
      qos_eff     = (req_item.qos_level == 2'd3) ? 2'd0 : req_item.qos_level;
      qnz         = (qos_eff != 2'd0);
      rem_sum     = 18'(req_item.topic_length) + 18'(req_item.payload_length) + 18'd2
                    + (qnz ? 18'd2 : 18'd0);
      too_long    = |rem_sum[17:16];
      topic_dec   = topic_left_ff - 16'd1;
      payload_dec = payload_left_ff - 16'd1;

      phase_in        = phase_ff;
      topic_left_in   = topic_left_ff;
      payload_left_in = payload_left_ff;
      held_qnz_in     = held_qnz_ff;
      held_pid_in     = held_pid_ff;

      cmd            = '0;
      cmd.err        = 1'b1;
      cmd.mask       = 8'b0000_0001;
      cmd.rem_len    = rem_sum[15:0];
      cmd.topic_len  = req_item.topic_length;
      cmd.pid        = held_pid_ff;

      if (req_item.opcode == mqpf_pkg::OP_START && phase_ff == mqpf_pkg::PH_IDLE
          && !too_long) begin
         cmd.err        = 1'b0;
         cmd.first_byte = mqpf_pkg::HEADER_BASE | {4'b0, req_item.dup_flag, qos_eff,
                                                   req_item.retain_flag};
         cmd.pid        = req_item.packet_id;
         cmd.mask[mqpf_pkg::SLOT_LEN0]    = 1'b1;
         cmd.mask[mqpf_pkg::SLOT_LEN1]    = |rem_sum[15:7];
         cmd.mask[mqpf_pkg::SLOT_LEN2]    = |rem_sum[15:14];
         cmd.mask[mqpf_pkg::SLOT_TLEN_HI] = 1'b1;
         cmd.mask[mqpf_pkg::SLOT_TLEN_LO] = 1'b1;
         topic_left_in   = req_item.topic_length;
         payload_left_in = req_item.payload_length;
         held_qnz_in     = qnz;
         held_pid_in     = req_item.packet_id;
         if (req_item.topic_length == 16'd0) begin
            cmd.mask[mqpf_pkg::SLOT_PID_HI] = qnz;
            cmd.mask[mqpf_pkg::SLOT_PID_LO] = qnz;
            cmd.end_after = (req_item.payload_length == 16'd0);
            phase_in = cmd.end_after ? mqpf_pkg::PH_IDLE : mqpf_pkg::PH_PAYLOAD;
         end else begin
            phase_in = mqpf_pkg::PH_TOPIC;
         end
      end else if (req_item.opcode == mqpf_pkg::OP_TOPIC
                   && phase_ff == mqpf_pkg::PH_TOPIC) begin
         cmd.err        = 1'b0;
         cmd.first_byte = req_item.data_byte;
         topic_left_in  = topic_dec;
         if (topic_dec == 16'd0) begin
            cmd.mask[mqpf_pkg::SLOT_PID_HI] = held_qnz_ff;
            cmd.mask[mqpf_pkg::SLOT_PID_LO] = held_qnz_ff;
            cmd.end_after = (payload_left_ff == 16'd0);
            phase_in = cmd.end_after ? mqpf_pkg::PH_IDLE : mqpf_pkg::PH_PAYLOAD;
         end
      end else if (req_item.opcode == mqpf_pkg::OP_PAYLOAD
                   && phase_ff == mqpf_pkg::PH_PAYLOAD) begin
         cmd.err         = 1'b0;
         cmd.first_byte  = req_item.data_byte;
         payload_left_in = payload_dec;
         cmd.end_after   = (payload_dec == 16'd0);
         if (cmd.end_after) begin
            phase_in = mqpf_pkg::PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= mqpf_pkg::PH_IDLE;
         topic_left_ff   <= '0;
         payload_left_ff <= '0;
         held_qnz_ff     <= 1'b0;
         held_pid_ff     <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         topic_left_ff   <= topic_left_in;
         payload_left_ff <= payload_left_in;
         held_qnz_ff     <= held_qnz_in;
         held_pid_ff     <= held_pid_in;
      end
   end

endmodule

[sv/mqpf_queue.sv]
module mqpf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  mqpf_pkg::cmd_type wr_cmd,
   output logic              q_full,
   input  logic              rd_en,
   output logic              q_empty,
   output mqpf_pkg::cmd_type rd_cmd
);

   mqpf_pkg::cmd_type slot_ff [mqpf_pkg::QUEUE_DEPTH];
   logic [mqpf_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [mqpf_pkg::QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      q_full   = (count_ff == (mqpf_pkg::QUEUE_AW+1)'(mqpf_pkg::QUEUE_DEPTH));
      q_empty  = (count_ff == '0);
      rd_cmd   = slot_ff[rd_ptr_ff];
      count_in = count_ff + (mqpf_pkg::QUEUE_AW+1)'(wr_en)
                 - (mqpf_pkg::QUEUE_AW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

[sv/mqpf_back.sv]
module mqpf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  mqpf_pkg::cmd_type      head,
   output logic                   q_pop,
   output logic                   empty,
   input  logic                   pop,
   output mqpf_pkg::rsp_item_type rsp_item
);

   logic [7:0] done_ff, done_in;
   logic       rsp_valid_ff, rsp_valid_in;
   mqpf_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [7:0] remaining;
   logic [7:0] rest;
   logic [2:0] slot;
   logic       found;
   logic       emit;
   logic       taken;
   logic [7:0] slot_byte;

   always_comb begin
      remaining = head.mask & ~done_ff;
      slot      = mqpf_pkg::SLOT_FIRST;
      found     = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!found && remaining[i]) begin
            slot  = 3'(i);
            found = 1'b1;
         end
      end
      rest = remaining & ~(8'b1 << slot);

      unique case (slot)
         mqpf_pkg::SLOT_FIRST:   slot_byte = head.err ? 8'd0 : head.first_byte;
         mqpf_pkg::SLOT_LEN0:    slot_byte = {head.mask[mqpf_pkg::SLOT_LEN1],
                                              head.rem_len[6:0]};
         mqpf_pkg::SLOT_LEN1:    slot_byte = {head.mask[mqpf_pkg::SLOT_LEN2],
                                              head.rem_len[13:7]};
         mqpf_pkg::SLOT_LEN2:    slot_byte = {6'd0, head.rem_len[15:14]};
         mqpf_pkg::SLOT_TLEN_HI: slot_byte = head.topic_len[15:8];
         mqpf_pkg::SLOT_TLEN_LO: slot_byte = head.topic_len[7:0];
         mqpf_pkg::SLOT_PID_HI:  slot_byte = head.pid[15:8];
         mqpf_pkg::SLOT_PID_LO:  slot_byte = head.pid[7:0];
         default:                slot_byte = 8'd0;
      endcase

      taken = pop && rsp_valid_ff;
      emit  = !q_empty && (!rsp_valid_ff || taken);
      q_pop = emit && (rest == 8'd0);

      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = slot_byte;
         rsp_in.last_byte   = head.end_after && (rest == 8'd0) && !head.err;
         rsp_in.error_flag  = head.err;
         done_in            = (rest == 8'd0) ? 8'd0 : (done_ff | (8'b1 << slot));
      end else if (taken) begin
         rsp_valid_in = 1'b0;
      end

      empty    = !rsp_valid_ff;
      rsp_item = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

[sv/mqtt_publish_packet_framer_top.sv]
// Channel   Direction  Handshake                     Payload
// input     in         push, full                    req_item  (req_item_type)
// result    out        empty, pop                    rsp_item  (rsp_item_type)
//
// Every item is accepted while push is high and full is low, and placed in a four-entry command queue.
// The back end sends one byte per cycle unless the result side stalls, so a start item
// gives four to eight bytes (one if refused), a topic byte one or three, payload one.
// Byte emission sets the sustained rate; a first byte goes through the queue, then rsp_ff.
// Reset is synchronous and returns the block to idle with the command queue and result register empty.
// A stalled result side fills the command queue, after which full holds off input.
module mqtt_publish_packet_framer_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  mqpf_pkg::req_item_type req_item,
   output logic                   empty,
   input  logic                   pop,
   output mqpf_pkg::rsp_item_type rsp_item
);

   mqpf_pkg::cmd_type front_cmd;
   mqpf_pkg::cmd_type head_cmd;
   logic              accept;
   logic              q_empty;
   logic              q_pop;

   assign accept = push && !full;

   mqpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .cmd      (front_cmd)
   );

   mqpf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_cmd  (front_cmd),
      .q_full  (full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_cmd  (head_cmd)
   );

   mqpf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head     (head_cmd),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

[verif/mqtt_publish_packet_framer_top_test.sv]
module mqtt_publish_packet_framer_top_test;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int REPORT_LIMIT = 50;
   localparam int REQ_W = $bits(mqpf_pkg::req_item_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   mqpf_pkg::req_item_type req_item = '0;
   logic empty;
   logic pop = 1'b0;
   mqpf_pkg::rsp_item_type rsp_item;

   mqtt_publish_packet_framer_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   // Expected packet bytes and the framer state they are computed from.
   mqpf_pkg::rsp_item_type expected_bytes[$];
   logic [1:0]   pkt_phase = mqpf_pkg::PH_IDLE;
   logic [15:0]  topic_remaining = '0;
   logic [15:0]  payload_remaining = '0;
   logic         pid_pending = 1'b0;
   logic [15:0]  held_pid = '0;

   int fail_count = 0;
   int items_sent = 0;
   int packets_framed = 0;
   int refused_items = 0;
   int bytes_checked = 0;
   int hold_left = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void emit(logic [7:0] value, logic last, logic err);
      mqpf_pkg::rsp_item_type r;
      r.out_byte = value;
      r.last_byte = last;
      r.error_flag = err;
      expected_bytes.push_back(r);
      if (last) begin
         packets_framed++;
      end
      if (err) begin
         refused_items++;
      end
   endfunction

   function automatic void close_topic();
      if (pid_pending) begin
         emit(held_pid[15:8], 1'b0, 1'b0);
         emit(held_pid[7:0], 1'b0, 1'b0);
      end
      if (payload_remaining == 16'd0) begin
         expected_bytes[expected_bytes.size() - 1].last_byte = 1'b1;
         packets_framed++;
         pkt_phase = mqpf_pkg::PH_IDLE;
      end else begin
         pkt_phase = mqpf_pkg::PH_PAYLOAD;
      end
   endfunction

   function automatic void frame_item(mqpf_pkg::req_item_type it);
      logic [1:0] q;
      logic [7:0] grp;
      int         total;
      q = (it.qos_level == 2'd3) ? 2'd0 : it.qos_level;
      if (it.opcode == mqpf_pkg::OP_START && pkt_phase == mqpf_pkg::PH_IDLE) begin
         total = 2 + it.topic_length + it.payload_length + ((q != 2'd0) ? 2 : 0);
         if (total > 65535) begin
            emit(8'h00, 1'b0, 1'b1);
         end else begin
            emit(mqpf_pkg::HEADER_BASE | {4'b0000, it.dup_flag, q, it.retain_flag},
                 1'b0, 1'b0);
            do begin
               grp = 8'(total & 127);
               total = total >> 7;
               if (total != 0) begin
                  grp[7] = 1'b1;
               end
               emit(grp, 1'b0, 1'b0);
            end while (total != 0);
            emit(it.topic_length[15:8], 1'b0, 1'b0);
            emit(it.topic_length[7:0], 1'b0, 1'b0);
            topic_remaining = it.topic_length;
            payload_remaining = it.payload_length;
            pid_pending = (q != 2'd0);
            held_pid = it.packet_id;
            if (topic_remaining == 16'd0) begin
               close_topic();
            end else begin
               pkt_phase = mqpf_pkg::PH_TOPIC;
            end
         end
      end else if (it.opcode == mqpf_pkg::OP_TOPIC && pkt_phase == mqpf_pkg::PH_TOPIC) begin
         emit(it.data_byte, 1'b0, 1'b0);
         topic_remaining = topic_remaining - 16'd1;
         if (topic_remaining == 16'd0) begin
            close_topic();
         end
      end else if (it.opcode == mqpf_pkg::OP_PAYLOAD
                   && pkt_phase == mqpf_pkg::PH_PAYLOAD) begin
         payload_remaining = payload_remaining - 16'd1;
         if (payload_remaining == 16'd0) begin
            pkt_phase = mqpf_pkg::PH_IDLE;
            emit(it.data_byte, 1'b1, 1'b0);
         end else begin
            emit(it.data_byte, 1'b0, 1'b0);
         end
      end else begin
         emit(8'h00, 1'b0, 1'b1);
      end
   endfunction

   function automatic mqpf_pkg::req_item_type make_start(logic [1:0] q, logic d, logic r,
                                                         logic [15:0] tlen,
                                                         logic [15:0] plen,
                                                         logic [15:0] pid);
      mqpf_pkg::req_item_type it;
      it = mqpf_pkg::req_item_type'(REQ_W'({$urandom, $urandom}));
      it.opcode = mqpf_pkg::OP_START;
      it.qos_level = q;
      it.dup_flag = d;
      it.retain_flag = r;
      it.topic_length = tlen;
      it.payload_length = plen;
      it.packet_id = pid;
      return it;
   endfunction

   function automatic mqpf_pkg::req_item_type make_data(logic [1:0] op, logic [7:0] value);
      mqpf_pkg::req_item_type it;
      it = mqpf_pkg::req_item_type'(REQ_W'({$urandom, $urandom}));
      it.opcode = op;
      it.data_byte = value;
      return it;
   endfunction

   // An item that the framer must refuse in its current phase.
   function automatic mqpf_pkg::req_item_type make_refused();
      mqpf_pkg::req_item_type it;
      logic [1:0]   op;
      it = mqpf_pkg::req_item_type'(REQ_W'({$urandom, $urandom}));
      do begin
         op = 2'($urandom);
      end while ((pkt_phase == mqpf_pkg::PH_TOPIC && op == mqpf_pkg::OP_TOPIC) ||
                 (pkt_phase == mqpf_pkg::PH_PAYLOAD && op == mqpf_pkg::OP_PAYLOAD));
      it.opcode = op;
      if (pkt_phase == mqpf_pkg::PH_IDLE && op == mqpf_pkg::OP_START) begin
         it.payload_length = 16'($urandom_range(65535, 65535 - it.topic_length));
      end
      return it;
   endfunction

   task automatic send_item(mqpf_pkg::req_item_type it);
      while (sender_idles && $urandom_range(99) < 20) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_item <= it;
      do begin
         @(posedge clock);
      end while (full);
      frame_item(it);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      push <= 1'b0;
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic send_bytes(logic [1:0] op, int count);
      for (int i = 0; i < count; i++) begin
         send_item(make_data(op, 8'($urandom)));
      end
   endtask

   task automatic send_packet(int tmax, int pmax);
      int tlen;
      int plen;
      tlen = $urandom_range(0, tmax);
      plen = $urandom_range(0, pmax);
      send_item(make_start(2'($urandom), 1'($urandom), 1'($urandom), 16'(tlen), 16'(plen),
                           16'($urandom)));
      for (int i = 0; i < tlen + plen; i++) begin
         if ($urandom_range(99) < 5) begin
            send_item(make_refused());
         end
         send_item(make_data((i < tlen) ? mqpf_pkg::OP_TOPIC : mqpf_pkg::OP_PAYLOAD,
                             8'($urandom)));
      end
   endtask

   task automatic test_directed();
      send_item(make_start(2'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFF));
      send_item(make_start(2'd1, 1'b1, 1'b1, 16'd0, 16'd0, 16'hA5C3));
      send_item(make_start(2'd3, 1'b1, 1'b0, 16'd2, 16'd1, 16'h1234));
      send_item(make_data(mqpf_pkg::OP_TOPIC, 8'h00));
      send_item(make_data(mqpf_pkg::OP_TOPIC, 8'hFF));
      send_item(make_data(mqpf_pkg::OP_PAYLOAD, 8'h80));
      send_item(make_start(2'd2, 1'b0, 1'b1, 16'd1, 16'd2, 16'hFFFF));
      send_item(make_data(mqpf_pkg::OP_PAYLOAD, 8'h11));
      send_item(make_data(mqpf_pkg::OP_TOPIC, 8'h7E));
      send_item(make_start(2'd1, 1'b1, 1'b1, 16'd5, 16'd5, 16'h5A5A));
      send_item(make_data(OP_UNUSED, 8'hC3));
      send_item(make_data(mqpf_pkg::OP_PAYLOAD, 8'hFF));
      send_item(make_data(mqpf_pkg::OP_PAYLOAD, 8'h00));
      send_item(make_data(mqpf_pkg::OP_TOPIC, 8'h55));
      send_item(make_data(mqpf_pkg::OP_PAYLOAD, 8'hAA));
      send_item(make_data(OP_UNUSED, 8'h3C));
      send_item(make_start(2'd2, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(make_start(2'd0, 1'b0, 1'b0, 16'hFFFD, 16'h0001, 16'h0000));
      send_item(make_start(2'd1, 1'b0, 1'b0, 16'hFFFB, 16'h0001, 16'h0000));
      send_item(make_start(2'd1, 1'b0, 1'b0, 16'd1, 16'd0, 16'h0000));
      send_item(make_data(mqpf_pkg::OP_TOPIC, 8'h2F));
      wait_for_drain();
   endtask

   task automatic test_length_encoding();
      send_item(make_start(2'd0, 1'b0, 1'b1, 16'd0, 16'd125, 16'h0F0F));
      send_bytes(mqpf_pkg::OP_PAYLOAD, 125);
      send_item(make_start(2'd2, 1'b1, 1'b0, 16'd4, 16'd120, 16'hF0F0));
      send_bytes(mqpf_pkg::OP_TOPIC, 4);
      send_bytes(mqpf_pkg::OP_PAYLOAD, 120);
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      sender_idles = 1'b0;
      hold_left = 300;
      for (int i = 0; i < 12; i++) begin
         send_packet(3, 3);
      end
      sender_idles = 1'b1;
      wait_for_drain();
   endtask

   // The largest accepted packet header, left open at the end of the run.
   task automatic test_longest_packet();
      send_item(make_start(2'd2, 1'b1, 1'b0, 16'd300, 16'd65231, 16'hFFFF));
      send_bytes(mqpf_pkg::OP_TOPIC, 4);
      send_item(make_refused());
      wait_for_drain();
   endtask

   task automatic test_random();
      int target;
      int k;
      target = items_sent + 200;
      k = 0;
      while (items_sent < target) begin
         if (k == 8) begin
            sender_idles = 1'b0;
            receiver_idles = 1'b0;
         end else if (k == 16) begin
            sender_idles = 1'b1;
            receiver_idles = 1'b1;
         end
         if ($urandom_range(99) < 12) begin
            send_item(make_refused());
         end else if ($urandom_range(99) < 5) begin
            send_packet(40, 60);
         end else begin
            send_packet(6, 8);
         end
         if ($urandom_range(99) < 5) begin
            wait_for_drain();
         end
         k++;
      end
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      wait_for_drain();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!receiver_idles) begin
         pop <= 1'b1;
      end else begin
         pop <= ($urandom_range(99) >= 20);
      end
   end

   task automatic report(string field, logic [7:0] want, logic [7:0] got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      mqpf_pkg::rsp_item_type want;
      if (!reset && pop && !empty) begin
         if (expected_bytes.size() == 0) begin
            report("unexpected item out_byte", 8'h00, rsp_item.out_byte);
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_item.out_byte !== want.out_byte) begin
               report("out_byte", want.out_byte, rsp_item.out_byte);
            end
            if (rsp_item.last_byte !== want.last_byte) begin
               report("last_byte", 8'(want.last_byte), 8'(rsp_item.last_byte));
            end
            if (rsp_item.error_flag !== want.error_flag) begin
               report("error_flag", 8'(want.error_flag), 8'(rsp_item.error_flag));
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_length_encoding();
      test_backpressure();
      test_random();
      test_longest_packet();
      $display("Sent %0d items: %0d packets framed, %0d items refused, %0d bytes checked.",
               items_sent, packets_framed, refused_items, bytes_checked);
      $display("Covered flags, QoS three, empty parts, length limits and stalls; %0d mismatches.",
               fail_count);
      if (fail_count == 0) begin
         $display("** mqtt_publish_packet_framer_top: PASSED **");
      end else begin
         $display("** mqtt_publish_packet_framer_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d bytes still expected.", expected_bytes.size());
      $display("** mqtt_publish_packet_framer_top: FAILED **");
      $finish;
   end

endmodule

[mqtt_publish_packet_framer_top.f]
sv/mqpf_pkg.sv
sv/mqpf_front.sv
sv/mqpf_queue.sv
sv/mqpf_back.sv
sv/mqtt_publish_packet_framer_top.sv
verif/mqtt_publish_packet_framer_top_test.sv
